@@ rtl/lpr_pkg.sv @@
package lpr_pkg;

    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned MAXLEN_W   = 31;

    localparam logic [MAXLEN_W-1:0] MAX_LENGTH_RESET = MAXLEN_W'(32'd32 << 20);

    localparam logic REG_MAX_LENGTH = 1'b0;

    localparam logic [2:0] ROLE_FRAME_LEN  = 3'd0;
    localparam logic [2:0] ROLE_COUNT      = 3'd1;
    localparam logic [2:0] ROLE_STRING_LEN = 3'd2;
    localparam logic [2:0] ROLE_DATA       = 3'd3;
    localparam logic [2:0] ROLE_IGNORED    = 3'd4;

    localparam logic [1:0] CMD_GET     = 2'd0;
    localparam logic [1:0] CMD_SET     = 2'd1;
    localparam logic [1:0] CMD_DEL     = 2'd2;
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    localparam int unsigned KM_GET  = 0;
    localparam int unsigned KM_SET  = 1;
    localparam int unsigned KM_DEL  = 2;
    localparam int unsigned KM_LEN3 = 3;

    localparam logic [23:0] KW_GET = "get";
    localparam logic [23:0] KW_SET = "set";
    localparam logic [23:0] KW_DEL = "del";

    typedef enum logic [2:0] {
        PH_FLEN,
        PH_COUNT,
        PH_SLEN,
        PH_DATA,
        PH_SKIP
    } t_phase;

    typedef struct packed {
        logic [7:0] byte_out;
        logic [2:0] byte_role;
        logic [7:0] string_index;
        logic       frame_end;
        logic [1:0] command;
        logic       close_now;
    } t_result;

    // Returns the match bits {del, set, get} of one keyword byte position.
    function automatic logic [2:0] kw_hits(input logic [7:0] b, input logic [1:0] pos);
        logic [7:0] g;
        logic [7:0] s;
        logic [7:0] d;
        case (pos)
            2'd0: begin
                g = KW_GET[23:16];
                s = KW_SET[23:16];
                d = KW_DEL[23:16];
            end
            2'd1: begin
                g = KW_GET[15:8];
                s = KW_SET[15:8];
                d = KW_DEL[15:8];
            end
            default: begin
                g = KW_GET[7:0];
                s = KW_SET[7:0];
                d = KW_DEL[7:0];
            end
        endcase
        return {b == d, b == s, b == g};
    endfunction

endpackage

@@ rtl/lpr_in_if.sv @@
interface lpr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source(output valid, output stream_byte, input ready);
    modport sink(input valid, input stream_byte, output ready);
endinterface

@@ rtl/lpr_out_if.sv @@
interface lpr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_out;
    logic [2:0] byte_role;
    logic [7:0] string_index;
    logic       frame_end;
    logic [1:0] command;
    logic       close_now;

    modport source(
        output valid, output byte_out, output byte_role, output string_index,
        output frame_end, output command, output close_now, input ready
    );
    modport sink(
        input valid, input byte_out, input byte_role, input string_index,
        input frame_end, input command, input close_now, output ready
    );
endinterface

@@ rtl/lpr_apb.sv @@
module lpr_apb
    import lpr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [MAXLEN_W-1:0]   o_max_length
);

    logic [MAXLEN_W-1:0] r_max_length;
    logic                w_write;
    logic                w_sel_max;

    assign pready    = 1'b1;
    assign w_sel_max = (paddr[2] == REG_MAX_LENGTH);
    assign w_write   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= MAX_LENGTH_RESET;
        end else if (w_write && w_sel_max) begin
            r_max_length <= pwdata[MAXLEN_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_sel_max) begin
            prdata = {{(APB_DATA_W - MAXLEN_W){1'b0}}, r_max_length};
        end
    end

    assign o_max_length = r_max_length;

endmodule

@@ rtl/lpr_core.sv @@
module lpr_core
    import lpr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_byte,
    input  logic [MAXLEN_W-1:0] i_max_length,
    output t_result             o_result
);

    t_phase              r_phase,  s_phase,  n_phase;
    logic [1:0]          r_wcnt,   s_wcnt,   n_wcnt;
    logic [23:0]         r_shift,  s_shift,  n_shift;
    logic [30:0]         r_fleft,  s_fleft,  n_fleft;
    logic [30:0]         r_sleft,  s_sleft,  n_sleft;
    logic [31:0]         r_bleft,  s_bleft,  n_bleft;
    logic [7:0]          r_scnt,   s_scnt,   n_scnt;
    logic                r_total2, s_total2, n_total2;
    logic                r_total3, s_total3, n_total3;
    logic [3:0]          r_km,     s_km,     n_km;
    logic                r_cfault, s_cfault, n_cfault;
    logic                r_closed, n_closed;

    logic [31:0] w_word;
    logic        w_word_done;
    logic        w_over;
    logic [30:0] w_fl_dec;
    logic [30:0] w_sl_dec;
    logic [7:0]  w_scnt_inc;
    logic [31:0] w_bl_dec;
    logic [2:0]  w_hits;
    logic        w_kw_check;
    logic        w_close;
    logic        w_fend;

    assign w_word      = {i_byte, r_shift};
    assign w_word_done = (r_wcnt == 2'd3);
    assign w_over      = (w_word > {1'b0, i_max_length});
    assign w_fl_dec    = (r_fleft != '0) ? r_fleft - 31'd1 : '0;
    assign w_sl_dec    = r_sleft - 31'd1;
    assign w_scnt_inc  = (r_scnt == 8'hFF) ? r_scnt : r_scnt + 8'd1;
    assign w_bl_dec    = r_bleft - 32'd1;
    assign w_hits      = kw_hits(i_byte, 2'(2'd3 - r_bleft[1:0]));
    assign w_kw_check  = (r_scnt == 8'd0) && r_km[KM_LEN3] &&
                         (r_bleft >= 32'd1) && (r_bleft <= 32'd3);

    // Next state.
    always_comb begin
        s_phase  = r_phase;
        s_wcnt   = r_wcnt;
        s_shift  = r_shift;
        s_fleft  = r_fleft;
        s_sleft  = r_sleft;
        s_bleft  = r_bleft;
        s_scnt   = r_scnt;
        s_total2 = r_total2;
        s_total3 = r_total3;
        s_km     = r_km;
        s_cfault = r_cfault;
        w_close  = 1'b0;
        w_fend   = 1'b0;

        if (!r_closed) begin
            if (r_phase == PH_FLEN) begin
                s_wcnt  = r_wcnt + 2'd1;
                s_shift = w_word[31:8];
                if (w_word_done) begin
                    if (w_over || w_word == '0) begin
                        w_close = 1'b1;
                    end else begin
                        s_fleft = w_word[30:0];
                        s_phase = PH_COUNT;
                    end
                end
            end else begin
                s_fleft = w_fl_dec;
                unique case (r_phase)
                    PH_COUNT: begin
                        s_wcnt  = r_wcnt + 2'd1;
                        s_shift = w_word[31:8];
                        if (w_word_done) begin
                            s_total2 = (w_word == 32'd2);
                            s_total3 = (w_word == 32'd3);
                            s_sleft  = w_word[30:0];
                            s_scnt   = '0;
                            if (w_over) begin
                                s_cfault = 1'b1;
                                s_phase  = PH_SKIP;
                            end else begin
                                s_phase = (w_word == '0) ? PH_SKIP : PH_SLEN;
                            end
                        end
                    end
                    PH_SLEN: begin
                        s_wcnt  = r_wcnt + 2'd1;
                        s_shift = w_word[31:8];
                        if (w_word_done) begin
                            s_bleft = w_word;
                            if (r_scnt == 8'd0) begin
                                s_km = (w_word == 32'd3) ? 4'hF : 4'h0;
                            end
                            if (w_word == '0) begin
                                s_sleft = w_sl_dec;
                                s_scnt  = w_scnt_inc;
                                s_phase = (w_sl_dec == '0) ? PH_SKIP : PH_SLEN;
                            end else begin
                                s_phase = PH_DATA;
                            end
                        end
                    end
                    PH_DATA: begin
                        if (w_kw_check) begin
                            s_km[KM_GET] = r_km[KM_GET] & w_hits[0];
                            s_km[KM_SET] = r_km[KM_SET] & w_hits[1];
                            s_km[KM_DEL] = r_km[KM_DEL] & w_hits[2];
                        end
                        s_bleft = w_bl_dec;
                        if (w_bl_dec == '0) begin
                            s_sleft = w_sl_dec;
                            s_scnt  = w_scnt_inc;
                            s_phase = (w_sl_dec == '0) ? PH_SKIP : PH_SLEN;
                        end
                    end
                    PH_SKIP: begin
                        s_cfault = 1'b1;
                    end
                    default: begin
                    end
                endcase
                if (w_fl_dec == '0) begin
                    if (s_cfault || s_phase != PH_SKIP) begin
                        w_close = 1'b1;
                    end else begin
                        w_fend = 1'b1;
                    end
                end
            end
        end

        n_phase  = s_phase;
        n_wcnt   = s_wcnt;
        n_shift  = s_shift;
        n_fleft  = s_fleft;
        n_sleft  = s_sleft;
        n_bleft  = s_bleft;
        n_scnt   = s_scnt;
        n_total2 = s_total2;
        n_total3 = s_total3;
        n_km     = s_km;
        n_cfault = s_cfault;
        n_closed = r_closed || w_close;

        if (w_fend) begin
            n_phase  = PH_FLEN;
            n_wcnt   = '0;
            n_shift  = '0;
            n_fleft  = '0;
            n_sleft  = '0;
            n_bleft  = '0;
            n_scnt   = '0;
            n_total2 = 1'b0;
            n_total3 = 1'b0;
            n_km     = 4'hF;
            n_cfault = 1'b0;
        end
    end

    // Result of the current item.
    always_comb begin
        o_result              = '0;
        o_result.byte_out     = i_byte;
        o_result.close_now    = w_close;
        o_result.frame_end    = w_fend;
        if (r_closed) begin
            o_result.byte_role = ROLE_IGNORED;
        end else begin
            unique case (r_phase)
                PH_FLEN:  o_result.byte_role = ROLE_FRAME_LEN;
                PH_COUNT: o_result.byte_role = ROLE_COUNT;
                PH_SLEN:  o_result.byte_role = ROLE_STRING_LEN;
                default:  o_result.byte_role = ROLE_DATA;
            endcase
            if (r_phase != PH_FLEN && r_phase != PH_COUNT) begin
                o_result.string_index = r_scnt;
            end
        end
        if (w_fend) begin
            o_result.command = CMD_UNKNOWN;
            if (s_km[KM_LEN3]) begin
                if (s_total2 && s_km[KM_GET]) begin
                    o_result.command = CMD_GET;
                end else if (s_total3 && s_km[KM_SET]) begin
                    o_result.command = CMD_SET;
                end else if (s_total2 && s_km[KM_DEL]) begin
                    o_result.command = CMD_DEL;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_FLEN;
            r_wcnt   <= '0;
            r_shift  <= '0;
            r_fleft  <= '0;
            r_sleft  <= '0;
            r_bleft  <= '0;
            r_scnt   <= '0;
            r_total2 <= 1'b0;
            r_total3 <= 1'b0;
            r_km     <= 4'hF;
            r_cfault <= 1'b0;
            r_closed <= 1'b0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_wcnt   <= n_wcnt;
            r_shift  <= n_shift;
            r_fleft  <= n_fleft;
            r_sleft  <= n_sleft;
            r_bleft  <= n_bleft;
            r_scnt   <= n_scnt;
            r_total2 <= n_total2;
            r_total3 <= n_total3;
            r_km     <= n_km;
            r_cfault <= n_cfault;
            r_closed <= n_closed;
        end
    end

endmodule

@@ rtl/length_prefixed_request_parser.sv @@
// Request deframer for a length-prefixed byte stream.
// The input channel i_in carries one stream byte per item. The output channel
// o_out returns one item per input byte: the byte, its role, its string index,
// a frame end flag with the decoded command, and a close flag for faults.
// A frame is a little-endian 32-bit length, a 32-bit string count and, per
// string, a 32-bit length and its data bytes. Once the stream is closed, every
// further byte comes back tagged as ignored.
// The largest allowed frame length and string count is set over the APB port
// at address 0 and should be written only while the block is idle.
// Items on o_out come from a registered buffer. One byte is taken every cycle
// while ready is high; parser state updates in the same cycle it is taken.
// A two-entry output buffer lets the block take a byte while a finished item
// waits, and ready drops only when both entries are full.
// Reset (synchronous, active low) starts a new frame, reopens the stream,
// empties the output buffer and restores the length limit to 32 MiB.
module length_prefixed_request_parser
    import lpr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    lpr_in_if.sink                i_in,
    lpr_out_if.source             o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [MAXLEN_W-1:0] w_max_length;
    t_result             w_result;
    t_result             r_main;
    t_result             r_skid;
    logic                r_main_v;
    logic                r_skid_v;
    logic                w_in_acc;
    logic                w_out_take;

    lpr_apb u_apb (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_max_length (w_max_length)
    );

    lpr_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_in_acc),
        .i_byte       (i_in.stream_byte),
        .i_max_length (w_max_length),
        .o_result     (w_result)
    );

    assign i_in.ready = !r_skid_v;
    assign w_in_acc   = i_in.valid && !r_skid_v;
    assign w_out_take = r_main_v && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (w_out_take) begin
                if (r_skid_v) begin
                    r_skid_v <= 1'b0;
                end else begin
                    r_main_v <= w_in_acc;
                end
            end else if (w_in_acc) begin
                if (!r_main_v) begin
                    r_main_v <= 1'b1;
                end else begin
                    r_skid_v <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_take) begin
            r_main <= r_skid_v ? r_skid : w_result;
        end else if (w_in_acc && !r_main_v) begin
            r_main <= w_result;
        end
        if (w_in_acc && r_main_v && !w_out_take) begin
            r_skid <= w_result;
        end
    end

    assign o_out.valid        = r_main_v;
    assign o_out.byte_out     = r_main.byte_out;
    assign o_out.byte_role    = r_main.byte_role;
    assign o_out.string_index = r_main.string_index;
    assign o_out.frame_end    = r_main.frame_end;
    assign o_out.command      = r_main.command;
    assign o_out.close_now    = r_main.close_now;

`ifndef SYNTH
    a_skid_needs_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_main_v)
        else $error("skid entry holds an item while the main entry is empty");

    a_closed_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_result.close_now) |=> (w_result.byte_role == ROLE_IGNORED))
        else $error("stream did not stay closed after a fault");

    a_end_or_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_result.frame_end && w_result.close_now))
        else $error("frame end and close reported on the same item");

    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !o_out.ready) |=> (r_skid_v && $stable(r_skid)))
        else $error("buffered item changed while the output was stalled");
`endif

endmodule

@@ sim/lpr_tag_checker.sv @@
`timescale 1ns / 1ps

module lpr_tag_checker
    import lpr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    lpr_in_if                     i_in_mon,
    lpr_out_if                    i_out_mon,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic                  pready,
    output int                    o_fail_count,
    output int                    o_pending
);

    t_phase        ph;
    logic [1:0]    word_cnt;
    logic [31:0]   word_acc;
    logic [31:0]   frame_left;
    logic [31:0]   strings_left;
    logic [31:0]   data_left;
    logic [31:0]   total_strings;
    logic [7:0]    str_idx;
    logic [3:0]    kw_match;
    logic          bad_content;
    logic          closed;
    logic [MAXLEN_W-1:0] max_len;

    t_result       tags_due[$];
    t_result       want;
    t_result       got;
    int            fails;

    function automatic void restart_frame();
        ph            = PH_FLEN;
        word_cnt      = '0;
        word_acc      = '0;
        frame_left    = '0;
        strings_left  = '0;
        data_left     = '0;
        str_idx       = '0;
        total_strings = '0;
        kw_match      = 4'hF;
        bad_content   = 1'b0;
    endfunction

    // Shifts one byte into the little-endian word and reports a complete word.
    function automatic bit shift_in(input logic [7:0] b);
        word_acc = {b, word_acc[31:8]};
        word_cnt = word_cnt + 2'd1;
        return word_cnt == 2'd0;
    endfunction

    function automatic void close_string();
        strings_left = strings_left - 1;
        if (str_idx != 8'hFF) str_idx = str_idx + 8'd1;
        ph = (strings_left == 0) ? PH_SKIP : PH_SLEN;
    endfunction

    function automatic t_result tag_stream_byte(input logic [7:0] b);
        t_result     r;
        t_phase      was;
        logic [31:0] word;
        r           = '0;
        r.byte_out  = b;
        r.byte_role = ROLE_IGNORED;
        r.command   = CMD_GET;
        if (closed) return r;
        if (ph == PH_FLEN) begin
            r.byte_role = ROLE_FRAME_LEN;
            if (shift_in(b)) begin
                word     = word_acc;
                word_acc = '0;
                if (word > {1'b0, max_len} || word == 0) begin
                    r.close_now = 1'b1;
                    closed      = 1'b1;
                end else begin
                    frame_left = word;
                    ph         = PH_COUNT;
                end
            end
            return r;
        end
        was = ph;
        case (was)
            PH_COUNT: r.byte_role = ROLE_COUNT;
            PH_SLEN:  r.byte_role = ROLE_STRING_LEN;
            default:  r.byte_role = ROLE_DATA;
        endcase
        r.string_index = (was == PH_COUNT) ? 8'd0 : str_idx;
        if (frame_left != 0) frame_left = frame_left - 1;
        case (was)
            PH_COUNT: begin
                if (shift_in(b)) begin
                    word          = word_acc;
                    word_acc      = '0;
                    total_strings = word;
                    strings_left  = word;
                    str_idx       = '0;
                    if (word > {1'b0, max_len}) begin
                        bad_content = 1'b1;
                        ph          = PH_SKIP;
                    end else begin
                        ph = (word == 0) ? PH_SKIP : PH_SLEN;
                    end
                end
            end
            PH_SLEN: begin
                if (shift_in(b)) begin
                    word      = word_acc;
                    word_acc  = '0;
                    data_left = word;
                    if (str_idx == 0) kw_match = (word == 3) ? 4'hF : 4'h0;
                    if (word == 0) close_string();
                    else ph = PH_DATA;
                end
            end
            PH_DATA: begin
                // Only the first string is matched against the keywords.
                if (str_idx == 0 && kw_match[KM_LEN3] && data_left >= 1 && data_left <= 3) begin
                    if (b != KW_GET[8*(data_left-1) +: 8]) kw_match[KM_GET] = 1'b0;
                    if (b != KW_SET[8*(data_left-1) +: 8]) kw_match[KM_SET] = 1'b0;
                    if (b != KW_DEL[8*(data_left-1) +: 8]) kw_match[KM_DEL] = 1'b0;
                end
                data_left = data_left - 1;
                if (data_left == 0) close_string();
            end
            default: bad_content = 1'b1;
        endcase
        if (frame_left == 0) begin
            if (bad_content || ph != PH_SKIP) begin
                r.close_now = 1'b1;
                closed      = 1'b1;
            end else begin
                r.frame_end = 1'b1;
                if (kw_match[KM_LEN3] && total_strings == 2 && kw_match[KM_GET])
                    r.command = CMD_GET;
                else if (kw_match[KM_LEN3] && total_strings == 3 && kw_match[KM_SET])
                    r.command = CMD_SET;
                else if (kw_match[KM_LEN3] && total_strings == 2 && kw_match[KM_DEL])
                    r.command = CMD_DEL;
                else
                    r.command = CMD_UNKNOWN;
                restart_frame();
            end
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] exp_val,
                                        input logic [7:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            max_len = MAX_LENGTH_RESET;
            restart_frame();
            closed = 1'b0;
            tags_due.delete();
            fails = 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == APB_ADDR_W'(4 * REG_MAX_LENGTH))
                max_len = pwdata[MAXLEN_W-1:0];
            if (i_in_mon.valid && i_in_mon.ready)
                tags_due = {tags_due, tag_stream_byte(i_in_mon.stream_byte)};
            if (i_out_mon.valid && i_out_mon.ready) begin
                got.byte_out     = i_out_mon.byte_out;
                got.byte_role    = i_out_mon.byte_role;
                got.string_index = i_out_mon.string_index;
                got.frame_end    = i_out_mon.frame_end;
                got.command      = i_out_mon.command;
                got.close_now    = i_out_mon.close_now;
                if (tags_due.size() == 0) begin
                    $error("output item with nothing expected, byte_out %0d", got.byte_out);
                    fails++;
                end else begin
                    want = tags_due.pop_front();
                    check_field("byte_out", want.byte_out, got.byte_out);
                    check_field("byte_role", 8'(want.byte_role), 8'(got.byte_role));
                    check_field("string_index", want.string_index, got.string_index);
                    check_field("frame_end", 8'(want.frame_end), 8'(got.frame_end));
                    check_field("command", 8'(want.command), 8'(got.command));
                    check_field("close_now", 8'(want.close_now), 8'(got.close_now));
                end
            end
        end
        o_pending    <= tags_due.size();
        o_fail_count <= fails;
    end

endmodule

@@ sim/length_prefixed_request_parser_tb.sv @@
`timescale 1ns / 1ps

module length_prefixed_request_parser_tb;
    import lpr_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int                    fail_count;
    int                    pending;
    int                    burst_left;
    logic [7:0]            req_body[$];

    lpr_in_if  in_ch();
    lpr_out_if out_ch();

    length_prefixed_request_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    lpr_tag_checker u_tag_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("[length_prefixed_request_parser] ERROR");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        req_body = {req_body, b};
    endfunction

    function automatic void add_word(input logic [31:0] w);
        for (int k = 0; k < 4; k++) add_byte(w[8*k +: 8]);
    endfunction

    function automatic void add_text(input logic [23:0] txt);
        for (int k = 2; k >= 0; k--) add_byte(txt[8*k +: 8]);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end else begin
            gap = pick_gap();
            if ($urandom_range(0, 29) == 0) burst_left = $urandom_range(20, 80);
        end
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.stream_byte <= b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic send_request(input logic [31:0] frame_len);
        for (int k = 0; k < 4; k++) send_byte(frame_len[8*k +: 8]);
        foreach (req_body[k]) send_byte(req_body[k]);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_max_length(input logic [MAXLEN_W-1:0] value);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * REG_MAX_LENGTH);
        pwdata  <= APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Builds a random request body no longer than limit, mostly commands.
    task automatic build_request(input int unsigned limit);
        int unsigned n;
        int unsigned len;
        int          kind;
        int          pos;
        logic [23:0] kw;
        do begin
            req_body.delete();
            kind = $urandom_range(0, 9);
            n = (kind < 7) ? $urandom_range(2, 3) : $urandom_range(0, 5);
            add_word(n);
            for (int unsigned s = 0; s < n; s++) begin
                if (s == 0 && kind < 8) begin
                    case ($urandom_range(0, 2))
                        0:       kw = KW_GET;
                        1:       kw = KW_SET;
                        default: kw = KW_DEL;
                    endcase
                    if ($urandom_range(0, 3) == 0) begin
                        pos = $urandom_range(0, 2);
                        kw[8*pos +: 8] = 8'($urandom);
                    end
                    add_word(3);
                    add_text(kw);
                end else begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
                                                      : $urandom_range(0, 8);
                    add_word(len);
                    repeat (len) add_byte(8'($urandom));
                end
            end
        end while (req_body.size() > limit);
    endtask

    initial begin : recv
        int run;
        int stall;
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            out_ch.ready <= 1'b1;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
            repeat (run) @(posedge i_clk);
            stall = pick_gap();
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    initial begin : stim
        int unsigned         random_bytes;
        int unsigned         n;
        int unsigned         frame_len;
        logic [MAXLEN_W-1:0] max_now;
        bit                  paused;
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.stream_byte <= '0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        burst_left        =  0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A frame with no strings, then del with an empty second string.
        req_body.delete();
        add_word(0);
        send_request(req_body.size());
        req_body.delete();
        add_word(2);
        add_word(3);
        add_text(KW_DEL);
        add_word(0);
        send_request(req_body.size());

        max_now = {MAXLEN_W{1'b1}};
        write_max_length(max_now);

        // A get keyword followed by many short strings in one frame.
        req_body.delete();
        n = $urandom_range(6, 12);
        add_word(n);
        add_word(3);
        add_text(KW_GET);
        repeat (n - 1) begin
            if ($urandom_range(0, 3) == 0) begin
                add_word(1);
                add_byte(8'($urandom));
            end else begin
                add_word(0);
            end
        end
        send_request(req_body.size());

        random_bytes = 0;
        paused = 1'b0;
        while (random_bytes < 200) begin
            build_request(200);
            send_request(req_body.size());
            random_bytes += 4 + req_body.size();
            if (!paused && random_bytes > 100) begin
                drain();
                paused = 1'b1;
            end
        end

        max_now = MAXLEN_W'($urandom_range(16, 48));
        write_max_length(max_now);
        req_body.delete();
        add_word(1);
        add_word(max_now - 8);
        repeat (max_now - 8) add_byte(8'($urandom));
        send_request(32'(max_now));
        while (random_bytes < 420) begin
            build_request(max_now);
            send_request(req_body.size());
            random_bytes += 4 + req_body.size();
        end

        case ($urandom_range(0, 4))
            0: begin
                if ($urandom_range(0, 1) == 0) max_now = '0;
                else max_now = MAXLEN_W'($urandom_range(0, 1000));
                write_max_length(max_now);
                req_body.delete();
                send_request(($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : max_now + 1);
            end
            1: begin
                req_body.delete();
                send_request(0);
            end
            2: begin
                max_now = MAXLEN_W'($urandom_range(8, 40));
                write_max_length(max_now);
                frame_len = $urandom_range(4, max_now);
                req_body.delete();
                add_word(($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : max_now + 1);
                repeat (frame_len - 4) add_byte(8'($urandom));
                send_request(frame_len);
            end
            3: begin
                build_request(max_now);
                repeat ($urandom_range(1, 5)) add_byte(8'($urandom));
                send_request(req_body.size());
            end
            default: begin
                build_request(max_now);
                send_request($urandom_range(1, req_body.size() - 1));
            end
        endcase
        repeat (30) send_byte(8'($urandom));

        drain();
        repeat (5) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[length_prefixed_request_parser] OK");
        end else begin
            $display("[length_prefixed_request_parser] ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/lpr_pkg.sv
rtl/lpr_in_if.sv
rtl/lpr_out_if.sv
rtl/lpr_apb.sv
rtl/lpr_core.sv
rtl/length_prefixed_request_parser.sv
sim/lpr_tag_checker.sv
sim/length_prefixed_request_parser_tb.sv
